/* rtl/eab_pkg.sv */
package eab_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int TURN_UNITS = 23040;
  localparam int QUARTER_UNITS = 5760;
  localparam int XY_W = 33;  // CORDIC x/y, Q.30 with headroom
  localparam int Z_W = 31;   // angle accumulator, degrees * 2^22
  localparam int SC_W = 32;  // sine/cosine, Q.30
  localparam int SUM_W = 34;
  localparam int Q14_ONE = 16384;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // atan(2^-i) in degrees * 2^22
  localparam logic signed [Z_W-1:0] ATAN_DEG22 [ATAN_ENTRIES] = '{
    31'sd188743680, 31'sd111421900, 31'sd58872272, 31'sd29884485,
    31'sd15000234, 31'sd7507429, 31'sd3754631, 31'sd1877430,
    31'sd938729, 31'sd469366, 31'sd234683, 31'sd117342,
    31'sd58671, 31'sd29335, 31'sd14668, 31'sd7334,
    31'sd3667, 31'sd1833, 31'sd917, 31'sd458,
    31'sd229, 31'sd115, 31'sd57, 31'sd29
  };

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } basis_t;

  // Q.30 product, round half up
  function automatic logic signed [SC_W-1:0] mul30(input logic signed [SC_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
    logic signed [63:0] p;
    p = (64'(a) * 64'(b)) + 64'sd536870912;
    return p[61:30];
  endfunction

  // Q.30 to Q1.14, round and clamp to +-1.0
  function automatic logic signed [15:0] to_q14(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + SUM_W'(32768)) >>> 16;
    if (r > SUM_W'(Q14_ONE)) r = SUM_W'(Q14_ONE);
    if (r < -SUM_W'(Q14_ONE)) r = -SUM_W'(Q14_ONE);
    return r[15:0];
  endfunction

endpackage

/* rtl/eab_cordic_stage.sv */
module eab_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic signed [eab_pkg::XY_W-1:0]    x_in,
  input  logic signed [eab_pkg::XY_W-1:0]    y_in,
  input  logic signed [eab_pkg::Z_W-1:0]     z_in,
  input  logic [1:0]                         q_in,
  output logic signed [eab_pkg::XY_W-1:0]    x_out,
  output logic signed [eab_pkg::XY_W-1:0]    y_out,
  output logic signed [eab_pkg::Z_W-1:0]     z_out,
  output logic [1:0]                         q_out
);

  logic signed [eab_pkg::XY_W-1:0] xs, ys;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_ff @(posedge clk) begin
    if (!z_in[eab_pkg::Z_W-1]) begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - eab_pkg::ATAN_DEG22[IDX];
    end else begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + eab_pkg::ATAN_DEG22[IDX];
    end
    q_out <= q_in;
  end

endmodule

/* rtl/eab_sincos.sv */
module eab_sincos #(
  parameter int STAGES = 16
) (
  input  logic                            clk,
  input  logic signed [15:0]              angle,
  output logic signed [eab_pkg::SC_W-1:0] sin_q30,
  output logic signed [eab_pkg::SC_W-1:0] cos_q30
);

  logic signed [eab_pkg::XY_W-1:0] x [STAGES+1];
  logic signed [eab_pkg::XY_W-1:0] y [STAGES+1];
  logic signed [eab_pkg::Z_W-1:0]  z [STAGES+1];
  logic [1:0]                      q [STAGES+1];

  logic signed [17:0] a_ext, t, r;
  logic [1:0]         quad;
  logic [12:0]        frac;

  // fold into one turn, then into a quadrant and a remainder
  always_comb begin
    a_ext = 18'(angle);
    t = angle[15] ? a_ext + 18'sd46080 : a_ext;
    r = (t >= 18'sd23040) ? t - 18'sd23040 : t;
    if (r >= 18'sd17280) begin
      quad = 2'd3;
      frac = 13'(r - 18'sd17280);
    end else if (r >= 18'sd11520) begin
      quad = 2'd2;
      frac = 13'(r - 18'sd11520);
    end else if (r >= 18'sd5760) begin
      quad = 2'd1;
      frac = 13'(r - 18'sd5760);
    end else begin
      quad = 2'd0;
      frac = r[12:0];
    end
  end

  always_ff @(posedge clk) begin
    x[0] <= eab_pkg::CORDIC_GAIN_Q30;
    y[0] <= '0;
    z[0] <= {2'b00, frac, 16'b0};
    q[0] <= quad;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    eab_cordic_stage #(.IDX(i)) u_stage (
      .clk  (clk),
      .x_in (x[i]), .y_in (y[i]), .z_in (z[i]), .q_in (q[i]),
      .x_out(x[i+1]), .y_out(y[i+1]), .z_out(z[i+1]), .q_out(q[i+1])
    );
  end

  logic signed [eab_pkg::XY_W-1:0] xf, yf;
  assign xf = x[STAGES];
  assign yf = y[STAGES];

  always_ff @(posedge clk) begin
    unique case (q[STAGES])
      2'd0: begin
        sin_q30 <= yf[eab_pkg::SC_W-1:0];
        cos_q30 <= xf[eab_pkg::SC_W-1:0];
      end
      2'd1: begin
        sin_q30 <= xf[eab_pkg::SC_W-1:0];
        cos_q30 <= -yf[eab_pkg::SC_W-1:0];
      end
      2'd2: begin
        sin_q30 <= -yf[eab_pkg::SC_W-1:0];
        cos_q30 <= -xf[eab_pkg::SC_W-1:0];
      end
      default: begin
        sin_q30 <= -xf[eab_pkg::SC_W-1:0];
        cos_q30 <= yf[eab_pkg::SC_W-1:0];
      end
    endcase
  end

endmodule

/* rtl/eab_basis.sv */
module eab_basis (
  input  logic                            clk,
  input  logic signed [eab_pkg::SC_W-1:0] sp,
  input  logic signed [eab_pkg::SC_W-1:0] cp,
  input  logic signed [eab_pkg::SC_W-1:0] sy,
  input  logic signed [eab_pkg::SC_W-1:0] cy,
  input  logic signed [eab_pkg::SC_W-1:0] sr,
  input  logic signed [eab_pkg::SC_W-1:0] cr,
  output eab_pkg::basis_t                 basis
);

  localparam int W = eab_pkg::SC_W;
  localparam int SW = eab_pkg::SUM_W;

  // first products
  logic signed [W-1:0] srsp, crsp, cpcy, cpsy, crsy, crcy, srcp, srsy, srcy, crcp;
  logic signed [W-1:0] sp1, cy1, sy1;
  always_ff @(posedge clk) begin
    srsp <= eab_pkg::mul30(sr, sp);
    crsp <= eab_pkg::mul30(cr, sp);
    cpcy <= eab_pkg::mul30(cp, cy);
    cpsy <= eab_pkg::mul30(cp, sy);
    crsy <= eab_pkg::mul30(cr, sy);
    crcy <= eab_pkg::mul30(cr, cy);
    srcp <= eab_pkg::mul30(sr, cp);
    srsy <= eab_pkg::mul30(sr, sy);
    srcy <= eab_pkg::mul30(sr, cy);
    crcp <= eab_pkg::mul30(cr, cp);
    sp1  <= sp;
    cy1  <= cy;
    sy1  <= sy;
  end

  // triple products
  logic signed [W-1:0] srspcy, srspsy, crspcy, crspsy;
  logic signed [W-1:0] cpcy2, cpsy2, crsy2, crcy2, srcp2, srsy2, srcy2, crcp2, sp2;
  always_ff @(posedge clk) begin
    srspcy <= eab_pkg::mul30(srsp, cy1);
    srspsy <= eab_pkg::mul30(srsp, sy1);
    crspcy <= eab_pkg::mul30(crsp, cy1);
    crspsy <= eab_pkg::mul30(crsp, sy1);
    cpcy2 <= cpcy;
    cpsy2 <= cpsy;
    crsy2 <= crsy;
    crcy2 <= crcy;
    srcp2 <= srcp;
    srsy2 <= srsy;
    srcy2 <= srcy;
    crcp2 <= crcp;
    sp2   <= sp1;
  end

  // sums and Q1.14 conversion
  always_ff @(posedge clk) begin
    basis.forward_x <= eab_pkg::to_q14(SW'(cpcy2));
    basis.forward_y <= eab_pkg::to_q14(SW'(cpsy2));
    basis.forward_z <= eab_pkg::to_q14(-SW'(sp2));
    basis.right_x   <= eab_pkg::to_q14(SW'(crsy2) - SW'(srspcy));
    basis.right_y   <= eab_pkg::to_q14(-SW'(srspsy) - SW'(crcy2));
    basis.right_z   <= eab_pkg::to_q14(-SW'(srcp2));
    basis.up_x      <= eab_pkg::to_q14(SW'(crspcy) + SW'(srsy2));
    basis.up_y      <= eab_pkg::to_q14(SW'(crspsy) - SW'(srcy2));
    basis.up_z      <= eab_pkg::to_q14(SW'(crcp2));
  end

endmodule

/* rtl/euler_angles_to_basis_vectors.sv */
// Throughput: one item per cycle; busy is never raised, the pipeline has no stall.
// The CORDIC stages and two multiplier ranks are all fully pipelined.
// Reset (rst, synchronous) clears only the valid chain; no done follows reset
// until new items have travelled the full pipeline. The receiver cannot stall.
module euler_angles_to_basis_vectors #(
  parameter int SINCOS_STAGES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  eab_pkg::angles_t in_item,
  output logic             done,
  output eab_pkg::basis_t  result
);

  // table holds 24 entries; more stages add nothing
  localparam int STAGES = (SINCOS_STAGES > eab_pkg::ATAN_ENTRIES) ?
                          eab_pkg::ATAN_ENTRIES : SINCOS_STAGES;
  // reduce (1) + CORDIC + quadrant fold (1) + two product ranks + output
  localparam int LAT = STAGES + 5;

  logic signed [eab_pkg::SC_W-1:0] sp, cp, sy, cy, sr, cr;
  logic [LAT-1:0] valid;

  assign busy = 1'b0;

  // three independent sine/cosine pipes, one per angle
  eab_sincos #(.STAGES(STAGES)) u_pitch (
    .clk(clk), .angle(in_item.pitch), .sin_q30(sp), .cos_q30(cp)
  );
  eab_sincos #(.STAGES(STAGES)) u_yaw (
    .clk(clk), .angle(in_item.yaw), .sin_q30(sy), .cos_q30(cy)
  );
  eab_sincos #(.STAGES(STAGES)) u_roll (
    .clk(clk), .angle(in_item.roll), .sin_q30(sr), .cos_q30(cr)
  );

  // products, sums and rounding into the output register
  eab_basis u_basis (
    .clk(clk), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
    .basis(result)
  );

  // item valid travels alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LAT-2:0], start & ~busy};
    end
  end

  assign done = valid[LAT-1];

`ifndef SYNTHESIS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("done without a matching start");

  a_up_z_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.up_z <= 16'sd16384 && result.up_z >= -16'sd16384))
    else $error("up_z out of range");

  a_fwd_x_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.forward_x <= 16'sd16384 && result.forward_x >= -16'sd16384))
    else $error("forward_x out of range");
`endif

endmodule
